FILE: src/piecewise_linear_colormap_lookup_defines.svh
// ----------------------------------------------------------------------------
// piecewise linear colormap lookup: assertion macros
// shared property forms used by the modules of the lookup block
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_COLORMAP_LOOKUP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLORMAP_LOOKUP_DEFINES_SVH

// same-cycle implication
`define PLCM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: property failed");

// next-cycle implication
`define PLCM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

FILE: src/plcm_pkg.sv
// ----------------------------------------------------------------------------
// plcm_pkg
// types, codes and constants of the piecewise linear colormap lookup
// ----------------------------------------------------------------------------
package plcm_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int TABLE_ENTRIES  = 256;

    localparam int POS_W  = 24;
    localparam int CH_W   = 16;
    localparam int NUM_CH = 3;
    localparam int DVD_W  = POS_W + CH_W;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic CFG_POINT_COUNT  = 1'b0;
    localparam logic CFG_OPACITY_MODE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NONMONO     = 2'd1;
    localparam logic [1:0] ST_MAX_LT_MIN  = 2'd2;
    localparam logic [1:0] ST_OPA_MAX_MIN = 2'd3;

    typedef struct packed {
        logic              action;
        logic [3:0]        point_index;
        logic signed [23:0] position;
        logic [15:0]       red_in;
        logic [15:0]       green_in;
        logic [15:0]       blue_in;
        logic [7:0]        query_index;
    } plcm_in_t;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [1:0]  status;
    } plcm_out_t;

    typedef struct packed {
        logic signed [POS_W-1:0]     position;
        logic [NUM_CH-1:0][CH_W-1:0] colour;
    } plcm_point_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [POS_W-1:0] divisor;
    } plcm_div_req_t;

    typedef struct packed {
        logic            busy;
        logic [CH_W-1:0] quotient;
    } plcm_div_rsp_t;

endpackage

FILE: src/piecewise_linear_colormap_lookup.sv
// ----------------------------------------------------------------------------
// piecewise_linear_colormap_lookup
// control point map with linear interpolation of colour at table entries
// ----------------------------------------------------------------------------
// A load word writes one control point. A query word ends without
// interpolation when the entry lies outside the map or the map fails its
// checks, reads one stored colour on an exact hit, and otherwise
// interpolates. The points in use are scanned one per cycle through the
// single read port of the point memory, and the three channels then run side
// by side through 16-step restoring dividers. A new word is taken as soon as
// the sequencer is back in idle, while the previous result may still wait in
// the output register. Point memory contents are undefined after reset; every
// point a query reaches must have been loaded.
`include "piecewise_linear_colormap_lookup_defines.svh"

module piecewise_linear_colormap_lookup #(
    parameter int MAX_POINTS = plcm_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  plcm_pkg::plcm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output plcm_pkg::plcm_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic                cfg_index,
    input  logic [4:0]          cfg_wdata
);

    localparam int PIDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int NCH    = plcm_pkg::NUM_CH;
    localparam int CW     = plcm_pkg::CH_W;
    localparam int PW     = plcm_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EVAL, S_RD_LO, S_RD_HI, S_MUL, S_DIV, S_FINISH
    } state_t;

    state_t state_reg;

    logic [4:0] point_count_reg;
    logic       opacity_mode_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_count_reg  <= 5'd2;
            opacity_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                plcm_pkg::CFG_POINT_COUNT:  point_count_reg  <= cfg_wdata;
                plcm_pkg::CFG_OPACITY_MODE: opacity_mode_reg <= cfg_wdata[0];
            endcase
        end
    end

    logic             s_fire;
    logic [CNT_W-1:0] used_points;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        if (point_count_reg == 5'd0) begin
            used_points = CNT_W'(1);
        end else if (32'(point_count_reg) > MAX_POINTS) begin
            used_points = CNT_W'(MAX_POINTS);
        end else begin
            used_points = CNT_W'(point_count_reg);
        end
    end

    // point memory
    logic                  mem_wr_en;
    plcm_pkg::plcm_point_t mem_wr_point;
    plcm_pkg::plcm_point_t mem_rd_point;
    logic [PIDX_W-1:0]     mem_rd_addr;
    logic [PIDX_W-1:0]     sel_idx;

    assign mem_wr_en = s_fire && (s_data.action == plcm_pkg::ACT_LOAD)
                       && (32'(s_data.point_index) < MAX_POINTS);
    assign mem_wr_point.position = s_data.position;
    assign mem_wr_point.colour   = {s_data.blue_in, s_data.green_in, s_data.red_in};

    plcm_point_mem #(
        .MAX_POINTS (MAX_POINTS),
        .PIDX_W     (PIDX_W)
    ) u_point_mem (
        .aclk     (aclk),
        .wr_en    (mem_wr_en),
        .wr_addr  (PIDX_W'(s_data.point_index)),
        .wr_point (mem_wr_point),
        .rd_addr  (mem_rd_addr),
        .rd_point (mem_rd_point)
    );

    // query context
    logic [7:0]               k_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [PIDX_W-1:0]        scan_idx_reg;
    logic [PIDX_W-1:0]        hi_idx_reg;
    logic                     hi_found_reg;
    logic                     nonmono_reg;
    logic                     exact_reg;
    logic signed [PW-1:0]     first_reg;
    logic signed [PW-1:0]     last_reg;
    logic signed [PW-1:0]     prev_reg;
    logic signed [PW-1:0]     p_lo_reg;
    logic signed [PW-1:0]     p_hi_reg;
    logic [PW-1:0]            num_reg;
    logic [PW-1:0]            den_reg;
    logic [NCH-1:0][CW-1:0]   c0_reg;
    logic [NCH-1:0][CW-1:0]   c1_reg;
    plcm_pkg::plcm_out_t      res_reg;
    logic                     m_valid_reg;
    plcm_pkg::plcm_out_t      m_data_reg;

    logic signed [PW:0] kpos;
    logic signed [PW:0] p_ext;
    logic signed [PW:0] first_ext;
    logic signed [PW:0] last_ext;
    logic signed [PW:0] p_lo_ext;
    logic signed [PW:0] p_hi_ext;
    logic signed [PW:0] num_full;
    logic signed [PW:0] den_full;
    logic               scan_last;
    logic [1:0]         eval_status;
    logic               in_range;

    assign kpos      = $signed({9'd0, k_reg, 8'd0});
    assign p_ext     = $signed({mem_rd_point.position[PW-1], mem_rd_point.position});
    assign first_ext = $signed({first_reg[PW-1], first_reg});
    assign last_ext  = $signed({last_reg[PW-1], last_reg});
    assign p_lo_ext  = $signed({p_lo_reg[PW-1], p_lo_reg});
    assign p_hi_ext  = $signed({p_hi_reg[PW-1], p_hi_reg});
    assign num_full  = kpos - p_lo_ext;
    assign den_full  = p_hi_ext - p_lo_ext;
    assign scan_last = ((CNT_W'(scan_idx_reg) + CNT_W'(1)) == n_reg);

    always_comb begin
        if (opacity_mode_reg && (last_reg <= first_reg)) begin
            eval_status = plcm_pkg::ST_OPA_MAX_MIN;
        end else if (!opacity_mode_reg && (last_reg < first_reg)) begin
            eval_status = plcm_pkg::ST_MAX_LT_MIN;
        end else if (nonmono_reg) begin
            eval_status = plcm_pkg::ST_NONMONO;
        end else begin
            eval_status = plcm_pkg::ST_OK;
        end
    end

    assign in_range = (eval_status == plcm_pkg::ST_OK)
                      && (32'(k_reg) < plcm_pkg::TABLE_ENTRIES)
                      && (kpos >= first_ext) && (kpos <= last_ext);

    always_comb begin
        if (first_reg == last_reg) begin
            sel_idx = '0;
        end else if (hi_found_reg) begin
            sel_idx = hi_idx_reg - PIDX_W'(1);
        end else begin
            sel_idx = PIDX_W'(n_reg - CNT_W'(1));
        end
    end

    always_comb begin
        case (state_reg)
            S_SCAN:  mem_rd_addr = scan_idx_reg + PIDX_W'(1);
            S_EVAL:  mem_rd_addr = sel_idx;
            S_RD_LO: mem_rd_addr = hi_idx_reg;
            default: mem_rd_addr = '0;
        endcase
    end

    // channel dividers
    plcm_pkg::plcm_div_req_t [NCH-1:0] div_req;
    plcm_pkg::plcm_div_rsp_t [NCH-1:0] div_rsp;
    logic [NCH-1:0][CW-1:0]            blend_out;

    for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
        logic                        up;
        logic [CW-1:0]               mag;
        logic [plcm_pkg::DVD_W-1:0]  prod;

        assign up   = (c1_reg[ch] >= c0_reg[ch]);
        assign mag  = up ? (c1_reg[ch] - c0_reg[ch]) : (c0_reg[ch] - c1_reg[ch]);
        assign prod = {{PW{1'b0}}, mag} * {{CW{1'b0}}, num_reg};

        assign div_req[ch].start    = (state_reg == S_MUL);
        assign div_req[ch].dividend = prod + plcm_pkg::DVD_W'(den_reg >> 1);
        assign div_req[ch].divisor  = den_reg;

        assign blend_out[ch] = up ? (c0_reg[ch] + div_rsp[ch].quotient)
                                  : (c0_reg[ch] - div_rsp[ch].quotient);

        plcm_divider u_divider (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (div_req[ch]),
            .rsp     (div_rsp[ch])
        );
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire && (s_data.action == plcm_pkg::ACT_QUERY)) begin
                        k_reg        <= s_data.query_index;
                        n_reg        <= used_points;
                        scan_idx_reg <= '0;
                        hi_found_reg <= 1'b0;
                        nonmono_reg  <= 1'b0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_idx_reg == '0) begin
                        first_reg <= mem_rd_point.position;
                    end else if (prev_reg > mem_rd_point.position) begin
                        nonmono_reg <= 1'b1;
                    end
                    if (!hi_found_reg && (p_ext > kpos)) begin
                        hi_found_reg <= 1'b1;
                        hi_idx_reg   <= scan_idx_reg;
                        p_hi_reg     <= mem_rd_point.position;
                        p_lo_reg     <= prev_reg;
                    end
                    prev_reg     <= mem_rd_point.position;
                    scan_idx_reg <= scan_idx_reg + PIDX_W'(1);
                    if (scan_last) begin
                        last_reg  <= mem_rd_point.position;
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    res_reg.status    <= eval_status;
                    res_reg.red_out   <= '0;
                    res_reg.green_out <= '0;
                    res_reg.blue_out  <= '0;
                    num_reg   <= num_full[PW-1:0];
                    den_reg   <= den_full[PW-1:0];
                    exact_reg <= (first_reg == last_reg) || !hi_found_reg
                                 || (p_lo_ext == kpos);
                    state_reg <= in_range ? S_RD_LO : S_FINISH;
                end
                S_RD_LO: begin
                    c0_reg <= mem_rd_point.colour;
                    if (exact_reg) begin
                        res_reg.red_out <= mem_rd_point.colour[0];
                        if (!opacity_mode_reg) begin
                            res_reg.green_out <= mem_rd_point.colour[1];
                            res_reg.blue_out  <= mem_rd_point.colour[2];
                        end
                        state_reg <= S_FINISH;
                    end else begin
                        state_reg <= S_RD_HI;
                    end
                end
                S_RD_HI: begin
                    c1_reg    <= mem_rd_point.colour;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (!div_rsp[0].busy) begin
                        res_reg.red_out <= blend_out[0];
                        if (!opacity_mode_reg) begin
                            res_reg.green_out <= blend_out[1];
                            res_reg.blue_out  <= blend_out[2];
                        end
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= res_reg;
                        state_reg   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PLCM_ASSERT_IMP(a_scan_in_map, aclk, aresetn, state_reg == S_SCAN, CNT_W'(scan_idx_reg) < n_reg)
    `PLCM_ASSERT_IMP(a_error_zero_colour, aclk, aresetn, m_valid_reg && (m_data_reg.status != plcm_pkg::ST_OK), (m_data_reg.red_out == '0) && (m_data_reg.green_out == '0) && (m_data_reg.blue_out == '0))

endmodule

FILE: src/plcm_point_mem.sv
// ----------------------------------------------------------------------------
// plcm_point_mem
// control point storage, one write and one registered read port
// ----------------------------------------------------------------------------
module plcm_point_mem #(
    parameter int MAX_POINTS = plcm_pkg::MAX_POINTS_DEF,
    parameter int PIDX_W     = $clog2(MAX_POINTS)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [PIDX_W-1:0]   wr_addr,
    input  plcm_pkg::plcm_point_t wr_point,
    input  logic [PIDX_W-1:0]   rd_addr,
    output plcm_pkg::plcm_point_t rd_point
);

    plcm_pkg::plcm_point_t point_mem [MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            point_mem[wr_addr] <= wr_point;
        end
        rd_point <= point_mem[rd_addr];
    end

endmodule

FILE: src/plcm_divider.sv
// ----------------------------------------------------------------------------
// plcm_divider
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
`include "piecewise_linear_colormap_lookup_defines.svh"

module plcm_divider (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  plcm_pkg::plcm_div_req_t req,
    output plcm_pkg::plcm_div_rsp_t rsp
);

    localparam int QW    = plcm_pkg::CH_W;
    localparam int DW    = plcm_pkg::POS_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;
    logic [DW-1:0]    div_reg;
    logic [DW+1:0]    trial;

    assign trial = {1'b0, rem_reg, quo_reg[QW-1]} - {2'b00, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QW);
            rem_reg  <= req.dividend[plcm_pkg::DVD_W-1:QW];
            quo_reg  <= req.dividend[QW-1:0];
            div_reg  <= req.divisor;
        end else if (busy_reg) begin
            if (!trial[DW+1]) begin
                rem_reg <= trial[DW-1:0];
            end else begin
                rem_reg <= {rem_reg[DW-2:0], quo_reg[QW-1]};
            end
            quo_reg <= {quo_reg[QW-2:0], ~trial[DW+1]};
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

    `PLCM_ASSERT_IMP(a_no_start_busy, aclk, aresetn, req.start, !busy_reg)
    `PLCM_ASSERT_NXT(a_start_busy, aclk, aresetn, req.start, busy_reg)
    `PLCM_ASSERT_IMP(a_rem_below_div, aclk, aresetn, $fell(busy_reg), rem_reg < div_reg)

endmodule
